>>> rtl/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types and constants of the Q16.16 three-component vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_SUB   = 3'd1,
    ACT_DOT   = 3'd2,
    ACT_SCALE = 3'd3,
    ACT_CROSS = 3'd4,
    ACT_MAG   = 3'd5,
    ACT_UNIT  = 3'd6
  } action_e;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned SqrtSteps = 32;  // one root bit per stage
  localparam int unsigned DivSteps  = 17;  // unit quotient lies in [0, 2^16]

  typedef logic signed [31:0] q16_t;

  localparam q16_t QMax = 32'sh7fff_ffff;
  localparam q16_t QMin = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0] action;
    q16_t       ux;
    q16_t       uy;
    q16_t       uz;
    q16_t       vx;
    q16_t       vy;
    q16_t       vz;
    q16_t       scale_factor;
  } in_item_t;

  typedef struct packed {
    q16_t rx;
    q16_t ry;
    q16_t rz;
    q16_t scalar_out;
  } out_item_t;

  // Square root section: radicand shifts out two bits per stage.
  typedef struct packed {
    logic [2:0]      action;
    q16_t [2:0]      u;
    out_item_t       res;
    logic [63:0]     rad;
    logic [33:0]     rem;
    logic [31:0]     root;
  } sqrt_pipe_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [16:0] quo;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic [2:0]       action;
    out_item_t        res;
    logic [31:0]      mag;
    div_lane_t [2:0]  lane;
  } div_pipe_t;

endpackage

>>> rtl/v3alu_front.sv
// ----------------------------------------------------------------------------
// v3alu_front
// Two stages: six 32x32 products and add/sub, then sums, floor shift, clamp.
// ----------------------------------------------------------------------------
module v3alu_front import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  in_item_t   item_i,
  output logic       valid_o,
  output sqrt_pipe_t pipe_o
);

  function automatic q16_t sat33(input logic signed [32:0] s);
    if (s[32] != s[31]) begin
      return s[32] ? QMin : QMax;
    end
    return s[31:0];
  endfunction

  // floor(t / 2^16), clamped to 32 bits
  function automatic q16_t sat_shr(input logic signed [65:0] t);
    logic signed [49:0] sh;
    sh = 50'(t >>> FracBits);
    if (sh[49:31] == {19{sh[49]}}) begin
      return sh[31:0];
    end
    return sh[49] ? QMin : QMax;
  endfunction

  q16_t               opa [6];
  q16_t               opb [6];
  logic signed [63:0] prod_d [6];
  out_item_t          vec_d;

  logic               s1_valid_q;
  logic [2:0]         s1_act_q;
  q16_t [2:0]         s1_u_q;
  logic signed [63:0] s1_prod_q [6];
  out_item_t          s1_vec_q;

  logic signed [65:0] w [6];
  sqrt_pipe_t         pipe_d;

  // ---- stage 1 ----
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    vec_d = '0;
    case (item_i.action)
      ACT_ADD: begin
        vec_d.rx = sat33(33'(item_i.ux) + 33'(item_i.vx));
        vec_d.ry = sat33(33'(item_i.uy) + 33'(item_i.vy));
        vec_d.rz = sat33(33'(item_i.uz) + 33'(item_i.vz));
      end
      ACT_SUB: begin
        vec_d.rx = sat33(33'(item_i.ux) - 33'(item_i.vx));
        vec_d.ry = sat33(33'(item_i.uy) - 33'(item_i.vy));
        vec_d.rz = sat33(33'(item_i.uz) - 33'(item_i.vz));
      end
      ACT_DOT: begin
        opa[0] = item_i.ux; opb[0] = item_i.vx;
        opa[1] = item_i.uy; opb[1] = item_i.vy;
        opa[2] = item_i.uz; opb[2] = item_i.vz;
      end
      ACT_SCALE: begin
        opa[0] = item_i.ux; opb[0] = item_i.scale_factor;
        opa[1] = item_i.uy; opb[1] = item_i.scale_factor;
        opa[2] = item_i.uz; opb[2] = item_i.scale_factor;
      end
      ACT_CROSS: begin
        opa[0] = item_i.uy; opb[0] = item_i.vz;
        opa[1] = item_i.uz; opb[1] = item_i.vx;
        opa[2] = item_i.ux; opb[2] = item_i.vy;
        opa[3] = item_i.uz; opb[3] = item_i.vy;
        opa[4] = item_i.ux; opb[4] = item_i.vz;
        opa[5] = item_i.uy; opb[5] = item_i.vx;
      end
      ACT_MAG, ACT_UNIT: begin
        opa[0] = item_i.ux; opb[0] = item_i.ux;
        opa[1] = item_i.uy; opb[1] = item_i.uy;
        opa[2] = item_i.uz; opb[2] = item_i.uz;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      prod_d[i] = opa[i] * opb[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_act_q <= item_i.action;
      s1_u_q   <= {item_i.uz, item_i.uy, item_i.ux};
      s1_vec_q <= vec_d;
      for (int i = 0; i < 6; i++) begin
        s1_prod_q[i] <= prod_d[i];
      end
    end
  end

  // ---- stage 2 ----
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      w[i] = 66'(s1_prod_q[i]);
    end
    pipe_d        = '0;
    pipe_d.action = s1_act_q;
    pipe_d.u      = s1_u_q;
    pipe_d.rad    = $unsigned(s1_prod_q[0]) + $unsigned(s1_prod_q[1])
                  + $unsigned(s1_prod_q[2]);
    case (s1_act_q)
      ACT_ADD, ACT_SUB: pipe_d.res = s1_vec_q;
      ACT_DOT:          pipe_d.res.scalar_out = sat_shr(w[0] + w[1] + w[2]);
      ACT_SCALE: begin
        pipe_d.res.rx = sat_shr(w[0]);
        pipe_d.res.ry = sat_shr(w[1]);
        pipe_d.res.rz = sat_shr(w[2]);
      end
      ACT_CROSS: begin
        pipe_d.res.rx = sat_shr(w[0] - w[3]);
        pipe_d.res.ry = sat_shr(w[1] - w[4]);
        pipe_d.res.rz = sat_shr(w[2] - w[5]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_o <= pipe_d;
    end
  end

endmodule

>>> rtl/v3alu_sqrt_step.sv
// ----------------------------------------------------------------------------
// v3alu_sqrt_step
// One restoring square-root stage: brings down two radicand bits, one root bit.
// ----------------------------------------------------------------------------
module v3alu_sqrt_step import v3alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  sqrt_pipe_t pipe_i,
  output logic       valid_o,
  output sqrt_pipe_t pipe_o
);

  logic [35:0] cur;
  logic [35:0] trial;
  logic        take;
  sqrt_pipe_t  pipe_d;

  always_comb begin
    cur         = {pipe_i.rem, pipe_i.rad[63:62]};
    trial       = {2'b00, pipe_i.root, 2'b01};
    take        = (cur >= trial);
    pipe_d      = pipe_i;
    pipe_d.rad  = {pipe_i.rad[61:0], 2'b00};
    pipe_d.rem  = take ? 34'(cur - trial) : cur[33:0];
    pipe_d.root = {pipe_i.root[30:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_o <= pipe_d;
    end
  end

  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pipe_o.rem <= 34'({pipe_o.root, 1'b0})))
    else $error("sqrt remainder out of bound");

endmodule

>>> rtl/v3alu_div_step.sv
// ----------------------------------------------------------------------------
// v3alu_div_step
// One restoring division stage for the three unit-vector lanes.
// ----------------------------------------------------------------------------
module v3alu_div_step import v3alu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_pipe_t pipe_i,
  output logic      valid_o,
  output div_pipe_t pipe_o
);

  logic [33:0] dvs;
  logic [33:0] diff [3];
  logic        take [3];
  div_pipe_t   pipe_d;

  always_comb begin
    dvs    = {2'b00, pipe_i.mag};
    pipe_d = pipe_i;
    for (int i = 0; i < 3; i++) begin
      take[i] = (pipe_i.lane[i].rem >= dvs);
      diff[i] = take[i] ? pipe_i.lane[i].rem - dvs : pipe_i.lane[i].rem;
      pipe_d.lane[i].rem = {diff[i][32:0], 1'b0};
      pipe_d.lane[i].quo = {pipe_i.lane[i].quo[15:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_o <= pipe_d;
    end
  end

  // shifted remainder stays below twice the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pipe_o.action == ACT_UNIT && pipe_o.mag != '0) |->
      (pipe_o.lane[0].rem < {1'b0, pipe_o.mag, 1'b0} &&
       pipe_o.lane[1].rem < {1'b0, pipe_o.mag, 1'b0} &&
       pipe_o.lane[2].rem < {1'b0, pipe_o.mag, 1'b0}))
    else $error("divider remainder out of bound");

endmodule

>>> rtl/vector3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Pipelined Q16.16 vector unit: add, sub, dot, scale, cross, magnitude, unit.
// ----------------------------------------------------------------------------
// Every transaction flows through the same 52-register pipeline: the registers
// are 2 front stages (operand select and six 32x32 multipliers, then the wide
// sums with floor shift and clamp), 32 square-root stages (one root bit each),
// 17 divider stages (one quotient bit each, three lanes for the unit vector)
// and the output register. A new transaction is accepted every cycle unless
// the pipeline is stalled. The whole pipeline advances whenever the output
// register is empty or being taken, so in_ready_o follows out_ready_i through
// that register; a stall freezes all stages in place. Action 7 returns all
// zeros.
module vector3_fixed_point_alu import v3alu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic       adv;
  logic       sq_valid [SqrtSteps+1];
  sqrt_pipe_t sq_pipe  [SqrtSteps+1];
  logic       dv_valid [DivSteps+1];
  div_pipe_t  dv_pipe  [DivSteps+1];
  sqrt_pipe_t sq_last;
  div_pipe_t  dv_last;
  div_pipe_t  dv_load;
  out_item_t  fin_d;
  logic [31:0] q_ext [3];
  q16_t        comp  [3];
  logic        out_valid_q;
  out_item_t   out_data_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // products, add/sub, sums and clamp
  v3alu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (sq_valid[0]),
    .pipe_o  (sq_pipe[0])
  );

  // integer square root of ux^2 + uy^2 + uz^2
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    v3alu_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_valid[g]),
      .pipe_i  (sq_pipe[g]),
      .valid_o (sq_valid[g+1]),
      .pipe_o  (sq_pipe[g+1])
    );
  end

  assign sq_last = sq_pipe[SqrtSteps];

  // magnitude result lands here; unit-vector lanes load |c| over m
  always_comb begin
    dv_load        = '0;
    dv_load.action = sq_last.action;
    dv_load.res    = sq_last.res;
    dv_load.mag    = sq_last.root;
    if (sq_last.action == ACT_MAG) begin
      dv_load.res.scalar_out = sq_last.root[31] ? QMax : q16_t'(sq_last.root);
    end
    for (int i = 0; i < 3; i++) begin
      dv_load.lane[i].neg = sq_last.u[i][31];
      dv_load.lane[i].rem = {2'b00, sq_last.u[i][31] ? 32'(-sq_last.u[i])
                                                     : 32'(sq_last.u[i])};
      dv_load.lane[i].quo = '0;
    end
  end

  assign dv_valid[0] = sq_valid[SqrtSteps];
  assign dv_pipe[0]  = dv_load;

  // (|c| * 2^16) / m, truncated
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    v3alu_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_valid[g]),
      .pipe_i  (dv_pipe[g]),
      .valid_o (dv_valid[g+1]),
      .pipe_o  (dv_pipe[g+1])
    );
  end

  assign dv_last = dv_pipe[DivSteps];

  // apply signs; zero magnitude normalizes to the zero vector
  always_comb begin
    fin_d = dv_last.res;
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = {15'd0, dv_last.lane[i].quo};
      comp[i]  = dv_last.lane[i].neg ? q16_t'(-q_ext[i]) : q16_t'(q_ext[i]);
    end
    if (dv_last.action == ACT_UNIT && dv_last.mag != '0) begin
      fin_d.rx = comp[0];
      fin_d.ry = comp[1];
      fin_d.rz = comp[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= fin_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // unit components never exceed 1.0 in magnitude
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid[DivSteps] && dv_last.action == ACT_UNIT && dv_last.mag != '0) |->
      (dv_last.lane[0].quo <= 17'd65536 && dv_last.lane[1].quo <= 17'd65536 &&
       dv_last.lane[2].quo <= 17'd65536))
    else $error("unit vector component above one");

  // a stall freezes the pipeline: no transaction moves between stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(dv_valid[DivSteps]) && $stable(sq_valid[SqrtSteps])))
    else $error("pipeline moved during stall");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the Q16.16 vector ALU against an in-bench predictor of each action.
// ----------------------------------------------------------------------------
// Directed corner items come first, then random ones in three idling phases.
// Every accepted input transaction pushes its predicted result; the monitor
// pops the oldest prediction on every accepted output transaction and
// compares it field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v3alu_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  vector3_fixed_point_alu dut (.*);

  always #1 clk_i = ~clk_i;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int        errors = 0;
  int        send_idle = 0;     // percent idle of the sender
  int        recv_idle = 0;     // percent stall of the receiver
  int        hold_cycles = 0;   // receiver long hold-off
  bit        send_pause = 1'b0;
  bit        in_taken = 1'b0;   // input transaction taken at the last rising edge
  longint    cycles = 0;

  // ---- predictor ----------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor((a+b)/2^16) saturated, summed exactly in 66 bits
  function automatic longint fix_sum(longint a, longint b);
    logic signed [65:0] s;
    s = 66'(signed'(a)) + 66'(signed'(b));
    s = s >>> FracBits;
    if (s > 66'sd2147483647) return 64'sd2147483647;
    if (s < -66'sd2147483648) return -64'sd2147483648;
    return longint'(s);
  endfunction

  function automatic longint fix_dot(longint a, longint b, longint c);
    logic signed [65:0] s;
    s = 66'(signed'(a)) + 66'(signed'(b)) + 66'(signed'(c));
    s = s >>> FracBits;
    if (s > 66'sd2147483647) return 64'sd2147483647;
    if (s < -66'sd2147483648) return -64'sd2147483648;
    return longint'(s);
  endfunction

  function automatic logic [63:0] root_floor(logic [65:0] s);
    logic [65:0] r, b;
    r = '0;
    b = 66'd1 << 64;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[63:0];
  endfunction

  function automatic longint unit_part(longint c, logic [63:0] m);
    logic [95:0] mag, q;
    mag = (c < 0) ? 96'(-c) : 96'(c);
    q = (mag << FracBits) / 96'(m);
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_item_t predict_vector_op(in_item_t it);
    out_item_t   r;
    longint      ux, uy, uz, vx, vy, vz, n;
    logic [65:0] sq;
    logic [63:0] m;
    ux = longint'(it.ux); uy = longint'(it.uy); uz = longint'(it.uz);
    vx = longint'(it.vx); vy = longint'(it.vy); vz = longint'(it.vz);
    n = longint'(it.scale_factor);
    r = '0;
    case (it.action)
      ACT_ADD: begin
        r.rx = q16_t'(clamp32(ux + vx));
        r.ry = q16_t'(clamp32(uy + vy));
        r.rz = q16_t'(clamp32(uz + vz));
      end
      ACT_SUB: begin
        r.rx = q16_t'(clamp32(ux - vx));
        r.ry = q16_t'(clamp32(uy - vy));
        r.rz = q16_t'(clamp32(uz - vz));
      end
      ACT_DOT: r.scalar_out = q16_t'(fix_dot(ux * vx, uy * vy, uz * vz));
      ACT_SCALE: begin
        r.rx = q16_t'(fix_sum(n * ux, 0));
        r.ry = q16_t'(fix_sum(n * uy, 0));
        r.rz = q16_t'(fix_sum(n * uz, 0));
      end
      ACT_CROSS: begin
        r.rx = q16_t'(fix_sum(uy * vz, -(uz * vy)));
        r.ry = q16_t'(fix_sum(uz * vx, -(ux * vz)));
        r.rz = q16_t'(fix_sum(ux * vy, -(uy * vx)));
      end
      ACT_MAG, ACT_UNIT: begin
        sq = 66'(64'(ux * ux)) + 66'(64'(uy * uy)) + 66'(64'(uz * uz));
        m = root_floor(sq);
        if (it.action == ACT_MAG) begin
          r.scalar_out = (m > 64'h7fff_ffff) ? QMax : q16_t'(m);
        end else if (m != 0) begin
          r.rx = q16_t'(unit_part(ux, m));
          r.ry = q16_t'(unit_part(uy, m));
          r.rz = q16_t'(unit_part(uz, m));
        end
      end
      default: r = '0;  // undefined action gives zeros
    endcase
    return r;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------
  function automatic q16_t pick_value();
    case ($urandom_range(0, 9))
      0: return QMax;
      1: return QMin;
      2: return q16_t'($urandom_range(0, 4)) - 2;
      3: return q16_t'($urandom_range(0, 2)) << 16;
      4, 5: return q16_t'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      default: return q16_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.action = ($urandom_range(0, 30) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    it.ux = pick_value(); it.uy = pick_value(); it.uz = pick_value();
    it.vx = pick_value(); it.vy = pick_value(); it.vz = pick_value();
    it.scale_factor = pick_value();
    return it;
  endfunction

  function automatic in_item_t make_item(logic [2:0] a, q16_t u, q16_t v, q16_t n);
    in_item_t it;
    it.action = a;
    it.ux = u; it.uy = u; it.uz = u; it.vx = v; it.vy = v; it.vz = v;
    it.scale_factor = n;
    return it;
  endfunction

  // ---- driver: change inputs on the falling edge --------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        // previous transaction was taken at the last rising edge
        if (pending_q.size() > 0 && !send_pause &&
            $urandom_range(0, 99) >= send_idle) begin
          in_data_i  <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: ready on the falling edge, long hold-off counted here ----
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Accepted input transactions predicted at the rising edge.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) expected_q.push_back(predict_vector_op(in_data_i));
  end

  // ---- monitor ------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.rx !== want.rx)
          $display("%0t: rx expected %h actual %h", $time, want.rx, out_data_o.rx);
        if (out_data_o.ry !== want.ry)
          $display("%0t: ry expected %h actual %h", $time, want.ry, out_data_o.ry);
        if (out_data_o.rz !== want.rz)
          $display("%0t: rz expected %h actual %h", $time, want.rz, out_data_o.rz);
        if (out_data_o.scalar_out !== want.scalar_out)
          $display("%0t: scalar_out expected %h actual %h", $time, want.scalar_out,
                   out_data_o.scalar_out);
        if (out_data_o !== want) errors++;
      end
    end
  end

  // Watchdog on a cycle counter.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
  endtask

  // ---- sequence -----------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed corners: every action at field extremes, zero unit, action 7
    for (int a = 0; a < 8; a++) begin
      pending_q.push_back(make_item(3'(a), QMax, QMax, QMax));
      pending_q.push_back(make_item(3'(a), QMin, QMax, QMin));
    end
    pending_q.push_back(make_item(ACT_UNIT, '0, QMin, '0));
    pending_q.push_back(make_item(ACT_MAG, '0, '0, '0));
    pending_q.push_back(make_item(ACT_UNIT, 32'sh0001_0000, '0, '0));
    pending_q.push_back(make_item(ACT_SCALE, -32'sd1, '0, 32'sh0000_8000));
    pending_q.push_back(make_item(ACT_DOT, -32'sd1, 32'sd1, '0));
    pending_q.push_back(make_item(ACT_UNIT, -32'sd1, '0, '0));

    send_idle = 11; recv_idle = 59;
    for (int i = 0; i < 430; i++) pending_q.push_back(random_item());
    wait_drained();

    // sender waits until every result is back, then long receiver hold-off
    send_pause = 1'b1;
    repeat (20) @(posedge clk_i);
    send_pause = 1'b0;
    send_idle = 59; recv_idle = 11;
    hold_cycles = 150;
    for (int i = 0; i < 430; i++) pending_q.push_back(random_item());
    wait_drained();

    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 430; i++) pending_q.push_back(random_item());
    wait_drained();

    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/v3alu_pkg.sv
rtl/v3alu_front.sv
rtl/v3alu_sqrt_step.sv
rtl/v3alu_div_step.sv
rtl/vector3_fixed_point_alu.sv
tb/testbench.sv
